// File: src/mdsd_pkg.sv
// shared constants and codes for the multichannel debounce and stuck detect block
package mdsd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned PIN_W      = 8;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_RESET = 7'd5;
  localparam logic [LIM_W-1:0] LIM_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 1'b1;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRANS  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STATUS = 2'd2;

  localparam logic KIND_TRANS  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [CODE_W-1:0] TCODE_NONE    = 2'd0;
  localparam logic [CODE_W-1:0] TCODE_RELEASE = 2'd1;
  localparam logic [CODE_W-1:0] TCODE_PRESS   = 2'd2;

  localparam logic [CODE_W-1:0] SCODE_RELEASED = 2'd0;
  localparam logic [CODE_W-1:0] SCODE_PRESSED  = 2'd1;
  localparam logic [CODE_W-1:0] SCODE_STUCK    = 2'd2;

endpackage

// File: src/multichannel_debounce_stuck_detect.sv
// A query request gives its answer on out_valid_o after the modify stage register and the
// output queue. A query can be taken back to back with the next while the output queue has
// room; a tick holds the channel memory port for a read-modify-write of each channel in turn,
// and no request is taken until that sweep ends. Answers wait in a two-entry output queue.
// Reset: registers go to their reset values and per-channel valid flops clear at once,
// so every channel reads as released with zero counters; no clearing pass is needed.
module multichannel_debounce_stuck_detect #(
  parameter int unsigned NUM_CHANNELS = mdsd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mdsd_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mdsd_pkg::PIN_W-1:0]      pin_levels_i,
  input  logic [mdsd_pkg::CH_W-1:0]       channel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            resp_kind_o,
  output logic [mdsd_pkg::CODE_W-1:0]     transition_code_o,
  output logic [mdsd_pkg::CODE_W-1:0]     status_code_o
);

  localparam int unsigned CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned RES_W = 1 + 2 * mdsd_pkg::CODE_W;

  typedef struct packed {
    logic                       cand;
    logic                       level;
    logic                       rel_ev;
    logic                       prs_ev;
    logic                       stuck;
    logic [mdsd_pkg::THR_W-1:0] settle;
    logic [mdsd_pkg::LIM_W-1:0] cdown;
  } entry_t;

  // configuration
  logic [mdsd_pkg::THR_W-1:0] thr_q;
  logic [mdsd_pkg::LIM_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= mdsd_pkg::THR_RESET;
      lim_q <= mdsd_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mdsd_pkg::CFG_THRESHOLD:   thr_q <= cfg_data_i[mdsd_pkg::THR_W-1:0];
        mdsd_pkg::CFG_STUCK_LIMIT: lim_q <= cfg_data_i[mdsd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // tick sweep
  logic                       sweep_q, sweep_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [mdsd_pkg::PIN_W-1:0] pins_q;

  // issue stage
  logic                       in_acc;
  logic                       iss_valid;
  logic [mdsd_pkg::REQ_W-1:0] iss_op;
  logic [CW-1:0]              iss_addr;
  logic                       iss_pressed;
  logic                       iss_inrange;
  logic                       room;

  // modify stage
  logic                       s1_valid_q;
  logic [mdsd_pkg::REQ_W-1:0] s1_op_q;
  logic [CW-1:0]              s1_addr_q;
  logic                       s1_pressed_q;
  logic                       s1_inrange_q;
  entry_t                     rd_q;
  logic                       rd_vld_q;
  logic                       byp_q;
  entry_t                     byp_data_q;
  entry_t                     cur;
  entry_t                     nxt;
  logic                       wr_en;
  logic                       push;
  logic [RES_W-1:0]           push_data;

  entry_t                     mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    vld_q;

  // output queue
  logic [RES_W-1:0]           oq_q [2];
  logic                       wptr_q, rptr_q;
  logic [1:0]                 ocnt_q;
  logic                       pop;
  logic [2:0]                 ahead;

  assign pop   = out_valid_o && out_ready_i;
  assign ahead = 3'(ocnt_q) + 3'(push) - 3'(pop);
  assign room  = (ahead <= 3'd1);

  assign in_ready_o = !sweep_q && room;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    iss_valid   = 1'b0;
    iss_op      = req_type_i;
    iss_addr    = '0;
    iss_pressed = !pin_levels_i[0];
    iss_inrange = 1'b1;
    if (sweep_q) begin
      iss_valid   = 1'b1;
      iss_op      = mdsd_pkg::REQ_TICK;
      iss_addr    = cnt_q;
      iss_pressed = (32'(cnt_q) < 32'd8) ? !pins_q[3'(cnt_q)] : 1'b0;
    end else if (in_acc) begin
      case (req_type_i)
        mdsd_pkg::REQ_TICK: begin
          iss_valid = 1'b1;
        end
        mdsd_pkg::REQ_TRANS, mdsd_pkg::REQ_STATUS: begin
          iss_valid   = 1'b1;
          iss_addr    = CW'(channel_i);
          iss_inrange = (32'(channel_i) < NUM_CHANNELS);
        end
        default: iss_valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    sweep_d = sweep_q;
    cnt_d   = cnt_q;
    if (sweep_q) begin
      if (cnt_q == CW'(NUM_CHANNELS - 1)) begin
        sweep_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (in_acc && req_type_i == mdsd_pkg::REQ_TICK && NUM_CHANNELS > 1) begin
      sweep_d = 1'b1;
      cnt_d   = CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == mdsd_pkg::REQ_TICK) begin
      pins_q <= pin_levels_i;
    end
  end

  // channel memory, registered read
  always_ff @(posedge clk_i) begin
    rd_q <= mem[iss_addr];
    if (wr_en) begin
      mem[s1_addr_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      byp_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      rd_vld_q   <= vld_q[iss_addr];
      byp_q      <= wr_en && (iss_addr == s1_addr_q);
      s1_valid_q <= iss_valid;
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q      <= iss_op;
    s1_addr_q    <= iss_addr;
    s1_pressed_q <= iss_pressed;
    s1_inrange_q <= iss_inrange;
    byp_data_q   <= nxt;
  end

  // read-modify-write of one channel entry
  always_comb begin
    logic [mdsd_pkg::THR_W-1:0] settle_inc;
    logic [mdsd_pkg::CODE_W-1:0] tcode;
    logic [mdsd_pkg::CODE_W-1:0] scode;
    cur        = byp_q ? byp_data_q : (rd_vld_q ? rd_q : '0);
    nxt        = cur;
    settle_inc = cur.settle + 1'b1;
    tcode      = mdsd_pkg::TCODE_NONE;
    scode      = mdsd_pkg::SCODE_RELEASED;
    wr_en      = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    if (s1_valid_q) begin
      case (s1_op_q)
        mdsd_pkg::REQ_TICK: begin
          wr_en = 1'b1;
          if (s1_pressed_q == cur.cand) begin
            nxt.settle = settle_inc;
            if (settle_inc >= thr_q) begin
              if (cur.cand && !cur.level) begin
                nxt.level  = 1'b1;
                nxt.prs_ev = 1'b1;
                nxt.rel_ev = 1'b0;
              end else if (!cur.cand && cur.level) begin
                nxt.level  = 1'b0;
                nxt.rel_ev = 1'b1;
                nxt.prs_ev = 1'b0;
              end
              nxt.settle = '0;
            end
          end else begin
            nxt.cand   = s1_pressed_q;
            nxt.settle = '0;
          end
          if (nxt.level) begin
            if (cur.cdown != '0) begin
              nxt.cdown = cur.cdown - 1'b1;
            end else begin
              nxt.stuck = 1'b1;
            end
          end else begin
            nxt.cdown = lim_q;
            nxt.stuck = 1'b0;
          end
        end
        mdsd_pkg::REQ_TRANS: begin
          push  = 1'b1;
          wr_en = s1_inrange_q;
          if (s1_inrange_q) begin
            if (cur.rel_ev) begin
              tcode      = mdsd_pkg::TCODE_RELEASE;
              nxt.rel_ev = 1'b0;
            end else if (cur.prs_ev) begin
              tcode      = mdsd_pkg::TCODE_PRESS;
              nxt.prs_ev = 1'b0;
            end
          end
          push_data = {mdsd_pkg::KIND_TRANS, tcode, mdsd_pkg::SCODE_RELEASED};
        end
        mdsd_pkg::REQ_STATUS: begin
          push = 1'b1;
          if (s1_inrange_q) begin
            if (cur.stuck) begin
              scode = mdsd_pkg::SCODE_STUCK;
            end else if (cur.level) begin
              scode = mdsd_pkg::SCODE_PRESSED;
            end
          end
          push_data = {mdsd_pkg::KIND_STATUS, mdsd_pkg::TCODE_NONE, scode};
        end
        default: ;
      endcase
    end
  end

  // answer queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      ocnt_q <= ahead[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[wptr_q] <= push_data;
    end
  end

  assign out_valid_o = (ocnt_q != 2'd0);
  assign {resp_kind_o, transition_code_o, status_code_o} = oq_q[rptr_q];

endmodule

// File: src/mdsd_checker.sv
// port-level checks for the debounce and stuck detect block, with its bind
module mdsd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [mdsd_pkg::REQ_W-1:0]      req_type_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            resp_kind_o,
  input logic [mdsd_pkg::CODE_W-1:0]     transition_code_o,
  input logic [mdsd_pkg::CODE_W-1:0]     status_code_o
);

  // answer stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("answer dropped before it was taken");

  // transition answer carries no status code
  a_trans_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_kind_o == mdsd_pkg::KIND_TRANS
    |-> status_code_o == mdsd_pkg::SCODE_RELEASED)
    else $error("status code set on transition answer");

  // status answer carries no transition code
  a_stat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_kind_o == mdsd_pkg::KIND_STATUS
    |-> transition_code_o == mdsd_pkg::TCODE_NONE)
    else $error("transition code set on status answer");

  // query accepted on an empty output shows its answer after the modify stage and output queue
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    (req_type_i == mdsd_pkg::REQ_TRANS || req_type_i == mdsd_pkg::REQ_STATUS)
    |=> ##1 out_valid_o)
    else $error("query answer late");

  // no answer after a reset edge
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("answer valid in reset");

endmodule

bind multichannel_debounce_stuck_detect mdsd_checker u_mdsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .req_type_i        (req_type_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .resp_kind_o       (resp_kind_o),
  .transition_code_o (transition_code_o),
  .status_code_o     (status_code_o)
);

// File: bench/testbench.sv
// self-checking bench for the multichannel debounce and stuck detect block
module testbench;

  localparam int unsigned NCH           = mdsd_pkg::NUM_CHANNELS_DEF;
  localparam logic [mdsd_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned SETTLE_CYCLES = NCH + 8;
  localparam int unsigned LONG_HOLD     = 90;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned NUM_PHASES    = 6;

  typedef logic [mdsd_pkg::REQ_W-1:0]      req_t;
  typedef logic [mdsd_pkg::PIN_W-1:0]      pins_t;
  typedef logic [mdsd_pkg::CH_W-1:0]       chan_t;
  typedef logic [mdsd_pkg::THR_W-1:0]      thr_t;
  typedef logic [mdsd_pkg::LIM_W-1:0]      lim_t;
  typedef logic [mdsd_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [mdsd_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic                        kind;
    logic [mdsd_pkg::CODE_W-1:0] tcode;
    logic [mdsd_pkg::CODE_W-1:0] scode;
  } answer_t;

  typedef struct packed {
    bit         is_cfg;
    req_t       req;
    pins_t      pins;
    chan_t      ch;
    logic [7:0] reps;
    bit         known;
    bit         known_has;
    answer_t    known_ans;
    thr_t       cfg_thr;
    lim_t       cfg_lim;
  } plan_step_t;

  localparam answer_t NO_ANSWER =
    '{mdsd_pkg::KIND_TRANS, mdsd_pkg::TCODE_NONE, mdsd_pkg::SCODE_RELEASED};

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  cfg_idx_t                    cfg_idx_i    = '0;
  cfg_data_t                   cfg_data_i   = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  req_t                        req_type_i   = '0;
  pins_t                       pin_levels_i = '1;
  chan_t                       channel_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        resp_kind_o;
  logic [mdsd_pkg::CODE_W-1:0] transition_code_o;
  logic [mdsd_pkg::CODE_W-1:0] status_code_o;

  multichannel_debounce_stuck_detect i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .pin_levels_i      (pin_levels_i),
    .channel_i         (channel_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .resp_kind_o       (resp_kind_o),
    .transition_code_o (transition_code_o),
    .status_code_o     (status_code_o)
  );

  // debouncer state as predicted
  logic cand_lvl    [NCH] = '{default: 1'b0};
  logic valid_lvl   [NCH] = '{default: 1'b0};
  logic release_evt [NCH] = '{default: 1'b0};
  logic press_evt   [NCH] = '{default: 1'b0};
  logic stuck_flg   [NCH] = '{default: 1'b0};
  thr_t settle_cnt  [NCH] = '{default: '0};
  lim_t stuck_cnt   [NCH] = '{default: '0};
  thr_t thr_cfg   = mdsd_pkg::THR_RESET;
  lim_t limit_cfg = mdsd_pkg::LIM_RESET;

  answer_t    pending_answers [$];
  plan_step_t plan [$];

  int unsigned mismatches      = 0;
  int unsigned answers_checked = 0;
  int unsigned ticks_sent      = 0;
  int unsigned queries_sent    = 0;
  int unsigned settings_used   = 0;
  int unsigned cycles          = 0;

  bit          steady_sender = 1'b0;
  bit          quiet         = 1'b0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned stall_left    = 0;
  int unsigned run_left      = 0;
  int unsigned burst_left    = 0;
  bit          bursty        = 1'b0;
  pins_t       held_pins     = '1;
  int unsigned hold_left     = 0;

  answer_t got_ans;
  answer_t want_ans;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void debounce_tick(pins_t pins);
    for (int c = 0; c < NCH; c++) begin
      logic smp;
      smp = (c < mdsd_pkg::PIN_W) ? ~pins[c] : 1'b0;
      if (smp == cand_lvl[c]) begin
        settle_cnt[c] = settle_cnt[c] + 1'b1;
        if (settle_cnt[c] >= thr_cfg) begin
          if (cand_lvl[c] && !valid_lvl[c]) begin
            valid_lvl[c]   = 1'b1;
            press_evt[c]   = 1'b1;
            release_evt[c] = 1'b0;
          end else if (!cand_lvl[c] && valid_lvl[c]) begin
            valid_lvl[c]   = 1'b0;
            release_evt[c] = 1'b1;
            press_evt[c]   = 1'b0;
          end
          settle_cnt[c] = '0;
        end
      end else begin
        cand_lvl[c]   = smp;
        settle_cnt[c] = '0;
      end
      if (valid_lvl[c]) begin
        if (stuck_cnt[c] != '0) stuck_cnt[c] = stuck_cnt[c] - 1'b1;
        else stuck_flg[c] = 1'b1;
      end else begin
        stuck_cnt[c] = limit_cfg;
        stuck_flg[c] = 1'b0;
      end
    end
  endfunction

  function automatic bit predict_request(req_t req, pins_t pins, chan_t ch,
                                         output answer_t ans);
    ans = NO_ANSWER;
    if (req == mdsd_pkg::REQ_TICK) begin
      debounce_tick(pins);
      return 1'b0;
    end
    if (req == mdsd_pkg::REQ_TRANS) begin
      if (ch < NCH) begin
        if (release_evt[ch]) begin
          ans.tcode = mdsd_pkg::TCODE_RELEASE;
          release_evt[ch] = 1'b0;
        end else if (press_evt[ch]) begin
          ans.tcode = mdsd_pkg::TCODE_PRESS;
          press_evt[ch] = 1'b0;
        end
      end
      return 1'b1;
    end
    if (req == mdsd_pkg::REQ_STATUS) begin
      ans.kind = mdsd_pkg::KIND_STATUS;
      if (ch < NCH) begin
        if (stuck_flg[ch]) ans.scode = mdsd_pkg::SCODE_STUCK;
        else if (valid_lvl[ch]) ans.scode = mdsd_pkg::SCODE_PRESSED;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void plan_req(req_t req, pins_t pins, chan_t ch, int reps);
    plan_step_t s;
    s      = '0;
    s.req  = req;
    s.pins = pins;
    s.ch   = ch;
    s.reps = 8'(reps);
    plan.push_back(s);
  endfunction

  function automatic void plan_known(req_t req, chan_t ch, bit has, answer_t ans);
    plan_step_t s;
    s           = '0;
    s.req       = req;
    s.pins      = 8'hff;
    s.ch        = ch;
    s.reps      = 8'd1;
    s.known     = 1'b1;
    s.known_has = has;
    s.known_ans = ans;
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(thr_t thr, lim_t lim);
    plan_step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.cfg_thr = thr;
    s.cfg_lim = lim;
    plan.push_back(s);
  endfunction

  task automatic send_req(input req_t req, input pins_t pins, input chan_t ch,
                          input bit known, input bit known_has, input answer_t known_ans);
    int unsigned gap;
    bit          has;
    answer_t     ans;
    gap = 0;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        bursty     = ($urandom_range(0, 1) != 0);
        burst_left = $urandom_range(10, 60);
      end
      burst_left--;
      if (bursty && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 13);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    pin_levels_i <= pins;
    channel_i    <= ch;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    has = predict_request(req, pins, ch, ans);
    if (known) begin
      has = known_has;
      ans = known_ans;
    end
    if (has) pending_answers.push_back(ans);
    if (req == mdsd_pkg::REQ_TICK) ticks_sent++;
    else if (req != REQ_UNKNOWN) queries_sent++;
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input thr_t thr, input lim_t lim);
    cfg_data_t data;
    drain_all();
    // upper bits beyond the threshold field are junk
    data        = cfg_data_t'($urandom);
    data[mdsd_pkg::THR_W-1:0] = thr;
    write_reg(mdsd_pkg::CFG_THRESHOLD, data);
    thr_cfg = data[mdsd_pkg::THR_W-1:0];
    write_reg(mdsd_pkg::CFG_STUCK_LIMIT, lim);
    limit_cfg = lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned query_pct);
    int unsigned k;
    int unsigned r;
    int unsigned eff_thr;
    req_t        req;
    pins_t       pins;
    chan_t       ch;
    k = 0;
    eff_thr = (thr_cfg == '0) ? 1 : int'(thr_cfg);
    while (k < n) begin
      r    = $urandom_range(0, 99);
      pins = pins_t'($urandom);
      ch   = chan_t'($urandom_range(0, 7));
      if (r < 3) begin
        req = REQ_UNKNOWN;
      end else if (r < 3 + query_pct) begin
        req = $urandom_range(0, 1) ? mdsd_pkg::REQ_TRANS : mdsd_pkg::REQ_STATUS;
        k++;
      end else begin
        req = mdsd_pkg::REQ_TICK;
        if (hold_left == 0) begin
          if ($urandom_range(0, 3) == 0) held_pins = pins_t'($urandom);
          else held_pins = held_pins ^ pins_t'($urandom & $urandom);
          hold_left = $urandom_range(1, 2 * eff_thr + 4);
        end
        hold_left--;
        // contact bounce on a few ticks
        if ($urandom_range(0, 9) == 0) pins = held_pins ^ pins_t'($urandom & $urandom);
        else pins = held_pins;
        k++;
      end
      send_req(req, pins, ch, 1'b0, 1'b0, NO_ANSWER);
    end
  endtask

  // receiver side with random backpressure and one long hold on demand
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      stall_left  = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready_i <= 1'b1;
    end else if (quiet || $urandom_range(0, 2) == 0) begin
      run_left = $urandom_range(1, 30);
      out_ready_i <= 1'b1;
    end else begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_ans = '{resp_kind_o, transition_code_o, status_code_o};
      answers_checked++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("answer %0d with nothing expected: kind %0d trans %0d status %0d",
                   answers_checked, got_ans.kind, got_ans.tcode, got_ans.scode);
      end else begin
        want_ans = pending_answers.pop_front();
        if (got_ans.kind !== want_ans.kind || got_ans.tcode !== want_ans.tcode ||
            got_ans.scode !== want_ans.scode) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("answer %0d mismatch: expected kind %0d trans %0d status %0d",
                     answers_checked, want_ans.kind, want_ans.tcode, want_ans.scode);
            $display("  got kind %0d trans %0d status %0d",
                     got_ans.kind, got_ans.tcode, got_ans.scode);
          end
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d answers outstanding", cycles,
             pending_answers.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    thr_t        phase_thr [NUM_PHASES];
    lim_t        phase_lim [NUM_PHASES];
    int unsigned phase_len [NUM_PHASES];
    int unsigned phase_qry [NUM_PHASES];
    phase_thr = '{7'd1, 7'd3, 7'd127, 7'd2, 7'd0, 7'd6};
    phase_lim = '{16'd0, 16'd12, 16'd4, 16'd65535, 16'd7, 16'd40};
    phase_len = '{150, 200, 300, 100, 100, 150};
    phase_qry = '{30, 30, 8, 30, 30, 30};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, then press, bounce and release under the default threshold
    plan_known(mdsd_pkg::REQ_STATUS, 3'd0, 1'b1,
               '{mdsd_pkg::KIND_STATUS, mdsd_pkg::TCODE_NONE, mdsd_pkg::SCODE_RELEASED});
    plan_known(mdsd_pkg::REQ_TRANS, 3'd7, 1'b1,
               '{mdsd_pkg::KIND_TRANS, mdsd_pkg::TCODE_NONE, mdsd_pkg::SCODE_RELEASED});
    plan_known(REQ_UNKNOWN, 3'd7, 1'b0, NO_ANSWER);
    plan_req(mdsd_pkg::REQ_TICK, 8'h00, 3'd0, 6);
    plan_known(mdsd_pkg::REQ_TRANS, 3'd0, 1'b1,
               '{mdsd_pkg::KIND_TRANS, mdsd_pkg::TCODE_PRESS, mdsd_pkg::SCODE_RELEASED});
    plan_known(mdsd_pkg::REQ_TRANS, 3'd0, 1'b1,
               '{mdsd_pkg::KIND_TRANS, mdsd_pkg::TCODE_NONE, mdsd_pkg::SCODE_RELEASED});
    plan_known(mdsd_pkg::REQ_STATUS, 3'd5, 1'b1,
               '{mdsd_pkg::KIND_STATUS, mdsd_pkg::TCODE_NONE, mdsd_pkg::SCODE_PRESSED});
    plan_req(mdsd_pkg::REQ_TICK, 8'hff, 3'd1, 1);
    plan_req(mdsd_pkg::REQ_TICK, 8'h00, 3'd2, 1);
    plan_req(mdsd_pkg::REQ_TICK, 8'hff, 3'd4, 6);
    plan_known(mdsd_pkg::REQ_TRANS, 3'd3, 1'b1,
               '{mdsd_pkg::KIND_TRANS, mdsd_pkg::TCODE_RELEASE, mdsd_pkg::SCODE_RELEASED});
    // threshold one with zero stuck limit flags a pressed channel as stuck at once
    plan_cfg(7'd1, 16'd0);
    plan_req(mdsd_pkg::REQ_TICK, 8'h55, 3'd0, 2);
    plan_req(mdsd_pkg::REQ_STATUS, 8'h00, 3'd0, 1);
    plan_req(mdsd_pkg::REQ_STATUS, 8'h00, 3'd1, 1);
    plan_req(mdsd_pkg::REQ_TRANS, 8'h00, 3'd1, 1);
    // zero threshold
    plan_cfg(7'd0, 16'd2);
    plan_req(mdsd_pkg::REQ_TICK, 8'haa, 3'd6, 2);
    plan_req(mdsd_pkg::REQ_TRANS, 8'haa, 3'd0, 1);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        set_config(plan[r].cfg_thr, plan[r].cfg_lim);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          send_req(plan[r].req, plan[r].pins, plan[r].ch, plan[r].known,
                   plan[r].known_has, plan[r].known_ans);
      end
    end

    // long receiver hold while queries keep coming
    drain_all();
    hold_asked++;
    steady_sender = 1'b1;
    for (int k = 0; k < 24; k++)
      send_req($urandom_range(0, 1) ? mdsd_pkg::REQ_TRANS : mdsd_pkg::REQ_STATUS,
               pins_t'($urandom), chan_t'($urandom_range(0, 7)), 1'b0, 1'b0, NO_ANSWER);
    steady_sender = 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_thr[p], phase_lim[p]);
      if (p == NUM_PHASES - 1) begin
        steady_sender = 1'b1;
        quiet         = 1'b1;
      end
      run_random(phase_len[p], phase_qry[p]);
    end

    drain_all();
    repeat (20) @(posedge clk_i);
    mismatches += pending_answers.size();

    $display("run covered %0d ticks and %0d queries over %0d register settings",
             ticks_sent, queries_sent, settings_used);
    $display("%0d answers checked, %0d mismatches", answers_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
